@@ rtl/matrix_scale_shear_decompose_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the decomposer
// ----------------------------------------------------------------------------
`ifndef MATRIX_SCALE_SHEAR_DECOMPOSE_TOP_DEFINES_SVH
`define MATRIX_SCALE_SHEAR_DECOMPOSE_TOP_DEFINES_SVH

// Clocked check, quiet while reset is high
`define MSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("msd check failed");

// Clocked check that also holds across reset
`define MSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("msd check failed");

`endif

@@ rtl/msd_pkg.sv @@
// ----------------------------------------------------------------------------
// msd_pkg
// Word types, status codes and datapath constants of the decomposer.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Digit width of the partial-product multipliers
  localparam int DIG_W  = 32;
  // Width of the square-root remainder datapath
  localparam int ROOT_W = 320;
  // Width of a root result (covers the value 2^31)
  localparam int Q_W    = 32;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_CORNER_ZERO = 2'd1,
    ST_ZERO_COL    = 2'd2
  } msd_status_t;

  typedef struct packed {
    logic signed [31:0] c0_x;
    logic signed [31:0] c0_y;
    logic signed [31:0] c0_z;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c1_z;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] c2_z;
    logic signed [31:0] corner_w;
  } msd_in_t;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] shear_yz;
    logic signed [31:0] shear_xz;
    logic signed [31:0] shear_xy;
    msd_status_t        status;
  } msd_out_t;

endpackage

@@ rtl/msd_mul.sv @@
// ----------------------------------------------------------------------------
// msd_mul
// Pipelined unsigned multiplier, one 32-bit digit of b per stage.
// ----------------------------------------------------------------------------
module msd_mul import msd_pkg::*; #(
  parameter int WA = 64,
  parameter int WB = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int NA = (WA + DIG_W - 1) / DIG_W;
  localparam int ND = (WB + DIG_W - 1) / DIG_W;
  localparam int PW = WA + WB;
  localparam int AP = NA * DIG_W;
  localparam int BP = ND * DIG_W;
  localparam int EW = AP + DIG_W;

  logic [AP-1:0] a_s [ND];
  logic [BP-1:0] b_s [ND];
  logic [PW-1:0] acc [ND];

  genvar j;
  generate
    for (j = 0; j < ND; j++) begin : g_dig
      logic [AP-1:0]    a_in;
      logic [BP-1:0]    b_in;
      logic [PW-1:0]    acc_in;
      logic [DIG_W-1:0] d;
      logic [EW-1:0]    ev;
      logic [EW-1:0]    od;
      logic [EW-1:0]    pd;

      if (j == 0) begin : g_first
        assign a_in   = AP'(a);
        assign b_in   = BP'(b);
        assign acc_in = '0;
      end else begin : g_next
        assign a_in   = a_s[j-1];
        assign b_in   = b_s[j-1];
        assign acc_in = acc[j-1];
      end

      assign d = b_in[j*DIG_W +: DIG_W];

      // Even and odd chunk products do not overlap: merge them with one add
      always_comb begin
        ev = '0;
        od = '0;
        for (int i = 0; i < NA; i++) begin
          if (i % 2 == 0) begin
            ev[i*DIG_W +: 2*DIG_W] = (2*DIG_W)'(a_in[i*DIG_W +: DIG_W]) *
                                     (2*DIG_W)'(d);
          end else begin
            od[i*DIG_W +: 2*DIG_W] = (2*DIG_W)'(a_in[i*DIG_W +: DIG_W]) *
                                     (2*DIG_W)'(d);
          end
        end
      end

      assign pd = ev + od;

      // Advance operands and accumulate this digit
      always_ff @(posedge clk) begin
        if (en) begin
          a_s[j] <= a_in;
          b_s[j] <= b_in;
          acc[j] <= acc_in + (PW'(pd) << (j*DIG_W));
        end
      end
    end
  endgenerate

  assign p = acc[ND-1];

endmodule

@@ rtl/msd_root.sv @@
// ----------------------------------------------------------------------------
// msd_root
// Pipelined floor(sqrt(x / y)), one result bit per stage, capped at 2^31.
// ----------------------------------------------------------------------------
module msd_root import msd_pkg::*; #(
  parameter int YW = 256
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] x,
  input  logic [YW-1:0]     y,
  output logic [Q_W-1:0]    q
);

  // Remainder r = x - q^2 y and running product p = q y travel per stage
  logic [ROOT_W-1:0] r_s [Q_W];
  logic [ROOT_W-1:0] p_s [Q_W];
  logic [YW-1:0]     y_s [Q_W];
  logic [Q_W-1:0]    q_s [Q_W];

  genvar i;
  generate
    for (i = 0; i < Q_W; i++) begin : g_bit
      localparam int K = Q_W - 1 - i;
      logic [ROOT_W-1:0] r_in;
      logic [ROOT_W-1:0] p_in;
      logic [YW-1:0]     y_in;
      logic [Q_W-1:0]    q_in;
      logic [ROOT_W-1:0] t;
      logic              take;

      if (i == 0) begin : g_first
        assign r_in = x;
        assign p_in = '0;
        assign y_in = y;
        assign q_in = '0;
      end else begin : g_next
        assign r_in = r_s[i-1];
        assign p_in = p_s[i-1];
        assign y_in = y_s[i-1];
        assign q_in = q_s[i-1];
      end

      // (q + 2^K)^2 y - q^2 y = 2^(K+1) q y + 2^(2K) y; stop once the cap is set
      always_comb begin
        t    = (p_in << (K + 1)) + (ROOT_W'(y_in) << (2 * K));
        take = !q_in[Q_W-1] && (t <= r_in);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          r_s[i] <= take ? r_in - t : r_in;
          p_s[i] <= take ? p_in + (ROOT_W'(y_in) << K) : p_in;
          y_s[i] <= y_in;
          q_s[i] <= q_in | (take ? (Q_W'(1) << K) : '0);
        end
      end
    end
  endgenerate

  assign q = q_s[Q_W-1];

endmodule

@@ rtl/matrix_scale_shear_decompose_top.sv @@
// ----------------------------------------------------------------------------
// matrix_scale_shear_decompose_top
// Scale and shear decomposition of a fixed-point affine 3x3 block.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one matrix word:
//   three columns and the corner element. The output channel (out_valid,
//   out_stall, out_data) returns one word per matrix with three scales,
//   three shears and a status code.
//   Throughput: one word per cycle while in_stall is low. Every stage is
//   a register stage that advances together; the longest section is
//   the 32-stage square root. A word passes an input register, a product
//   stage, a sum stage, the second-level multipliers, a second sum stage,
//   the third- and fourth-level multipliers, 32 root stages, an output stage.
//   When out_stall holds a result, the next result lands in a skid register
//   and in_stall rises at that same edge; the pipeline freezes, nothing is
//   lost.
//   Reset (rst, synchronous) empties the pipeline and both output registers.
// ----------------------------------------------------------------------------
module matrix_scale_shear_decompose_top import msd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  msd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output msd_out_t out_data
);

  localparam int L2_LAT = 64 / DIG_W;
  localparam int L3_LAT = 128 / DIG_W;
  localparam int L4_LAT = 64 / DIG_W;
  localparam int VLEN   = 3 + L2_LAT + 1 + L3_LAT + L4_LAT + Q_W;

  typedef struct packed {
    logic [2:0]  abac_n;
    logic [2:0]  abc_n;
    logic [63:0] aa;
    logic [63:0] w2;
    logic        dabn;
    logic        dacn;
    logic        wz;
    logic        wn;
  } side2_t;

  typedef struct packed {
    logic neg_s;
    logic tripn;
    logic dacn;
    logic dabn;
    logic wz;
    logic deg;
  } flags_t;

  typedef struct packed {
    logic [127:0] ab2;
    logic [127:0] aaw2;
    logic [127:0] dab2;
    logic [63:0]  aa;
    logic [63:0]  w2;
    flags_t       f;
  } side5_t;

  typedef struct packed {
    logic [191:0] det2;
    logic [255:0] ab2w2;
    logic [255:0] trip2;
    logic [255:0] dac2ab2;
    logic [127:0] ab2;
    logic [127:0] aaw2;
    logic [127:0] dab2;
    logic [63:0]  aa;
    logic [63:0]  w2;
    flags_t       f;
  } side9_t;

  // Saturate a root to a signed field, or negate it
  function automatic logic [31:0] fmt(input logic [31:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = 32'(32'd0 - q);
    end else if (q[31]) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = q;
    end
    return r;
  endfunction

  logic            en;
  logic            skid_valid;
  msd_out_t        skid;
  logic [VLEN-1:0] v;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[VLEN-2:0], in_valid};
    end
  end

  // Stage 0: register the input word
  msd_in_t x0;
  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= in_data;
    end
  end

  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic signed [31:0] c [3];
  assign a[0] = x0.c0_x;
  assign a[1] = x0.c0_y;
  assign a[2] = x0.c0_z;
  assign b[0] = x0.c1_x;
  assign b[1] = x0.c1_y;
  assign b[2] = x0.c1_z;
  assign c[0] = x0.c2_x;
  assign c[1] = x0.c2_y;
  assign c[2] = x0.c2_z;

  // Stage 1: all 32x32 products
  logic signed [63:0] abp1 [3];
  logic signed [63:0] abp2 [3];
  logic signed [63:0] acp1 [3];
  logic signed [63:0] acp2 [3];
  logic signed [63:0] bcp1 [3];
  logic signed [63:0] bcp2 [3];
  logic signed [63:0] aap  [3];
  logic signed [63:0] dabp [3];
  logic signed [63:0] dacp [3];
  logic signed [63:0] w2p;
  logic signed [31:0] a1 [3];
  logic               wz1;
  logic               wn1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        abp1[i] <= 64'(a[(i+1)%3]) * 64'(b[(i+2)%3]);
        abp2[i] <= 64'(a[(i+2)%3]) * 64'(b[(i+1)%3]);
        acp1[i] <= 64'(a[(i+1)%3]) * 64'(c[(i+2)%3]);
        acp2[i] <= 64'(a[(i+2)%3]) * 64'(c[(i+1)%3]);
        bcp1[i] <= 64'(b[(i+1)%3]) * 64'(c[(i+2)%3]);
        bcp2[i] <= 64'(b[(i+2)%3]) * 64'(c[(i+1)%3]);
        aap[i]  <= 64'(a[i]) * 64'(a[i]);
        dabp[i] <= 64'(a[i]) * 64'(b[i]);
        dacp[i] <= 64'(a[i]) * 64'(c[i]);
        a1[i]   <= a[i];
      end
      w2p <= 64'(x0.corner_w) * 64'(x0.corner_w);
      wz1 <= (x0.corner_w == 32'sd0);
      wn1 <= x0.corner_w[31];
    end
  end

  // Stage 2: cross products and dots, split into sign and magnitude
  logic signed [64:0] abs_s [3];
  logic signed [64:0] acs_s [3];
  logic signed [64:0] bcs_s [3];
  logic signed [65:0] dab_s;
  logic signed [65:0] dac_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_s[i] = 65'(abp1[i]) - 65'(abp2[i]);
      acs_s[i] = 65'(acp1[i]) - 65'(acp2[i]);
      bcs_s[i] = 65'(bcp1[i]) - 65'(bcp2[i]);
    end
    dab_s = 66'(dabp[0]) + 66'(dabp[1]) + 66'(dabp[2]);
    dac_s = 66'(dacp[0]) + 66'(dacp[1]) + 66'(dacp[2]);
  end

  logic [63:0] abm [3];
  logic [63:0] acm [3];
  logic [63:0] bcm [3];
  logic [31:0] am  [3];
  logic [2:0]  abn;
  logic [2:0]  acn;
  logic [2:0]  bcn;
  logic [2:0]  an;
  logic [63:0] aa2;
  logic [63:0] w2_2;
  logic [63:0] dabm;
  logic [63:0] dacm;
  logic        dabn2;
  logic        dacn2;
  logic        wz2;
  logic        wn2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        abm[i] <= abs_s[i][64] ? 64'(-abs_s[i]) : 64'(abs_s[i]);
        acm[i] <= acs_s[i][64] ? 64'(-acs_s[i]) : 64'(acs_s[i]);
        bcm[i] <= bcs_s[i][64] ? 64'(-bcs_s[i]) : 64'(bcs_s[i]);
        am[i]  <= a1[i][31] ? 32'(32'd0 - a1[i]) : 32'(a1[i]);
        abn[i] <= abs_s[i][64];
        acn[i] <= acs_s[i][64];
        bcn[i] <= bcs_s[i][64];
        an[i]  <= a1[i][31];
      end
      aa2   <= 64'(aap[0]) + 64'(aap[1]) + 64'(aap[2]);
      w2_2  <= 64'(w2p);
      dabm  <= dab_s[65] ? 64'(-dab_s) : 64'(dab_s);
      dacm  <= dac_s[65] ? 64'(-dac_s) : 64'(dac_s);
      dabn2 <= dab_s[65];
      dacn2 <= dac_s[65];
      wz2   <= wz1;
      wn2   <= wn1;
    end
  end

  // Second multiply level
  logic [127:0] abab [3];
  logic [127:0] abac [3];
  logic [95:0]  abc  [3];
  logic [127:0] dac2;
  logic [127:0] dab2;
  logic [127:0] aaw2;

  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_l2
      msd_mul #(.WA(64), .WB(64)) u_abab (
        .clk(clk), .en(en), .a(abm[gi]), .b(abm[gi]), .p(abab[gi]));
      msd_mul #(.WA(64), .WB(64)) u_abac (
        .clk(clk), .en(en), .a(abm[gi]), .b(acm[gi]), .p(abac[gi]));
      msd_mul #(.WA(32), .WB(64)) u_abc (
        .clk(clk), .en(en), .a(am[gi]), .b(bcm[gi]), .p(abc[gi]));
    end
  endgenerate

  msd_mul #(.WA(64), .WB(64)) u_dac2 (
    .clk(clk), .en(en), .a(dacm), .b(dacm), .p(dac2));
  msd_mul #(.WA(64), .WB(64)) u_dab2 (
    .clk(clk), .en(en), .a(dabm), .b(dabm), .p(dab2));
  msd_mul #(.WA(64), .WB(64)) u_aaw2 (
    .clk(clk), .en(en), .a(aa2), .b(w2_2), .p(aaw2));

  side2_t sd2 [L2_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      sd2[0] <= '{abac_n: abn ^ acn, abc_n: an ^ bcn, aa: aa2, w2: w2_2,
                  dabn: dabn2, dacn: dacn2, wz: wz2, wn: wn2};
      for (int i = 1; i < L2_LAT; i++) begin
        sd2[i] <= sd2[i-1];
      end
    end
  end

  // Stage 5: sum squares, determinant and triple product; flag degenerate frames
  side2_t              s2o;
  logic [127:0]        ab2_c;
  logic signed [97:0]  det_c;
  logic signed [129:0] trip_c;

  assign s2o = sd2[L2_LAT-1];

  always_comb begin
    ab2_c  = abab[0] + abab[1] + abab[2];
    det_c  = '0;
    trip_c = '0;
    for (int i = 0; i < 3; i++) begin
      det_c  = s2o.abc_n[i]  ? det_c  - 98'(abc[i])  : det_c  + 98'(abc[i]);
      trip_c = s2o.abac_n[i] ? trip_c - 130'(abac[i]) : trip_c + 130'(abac[i]);
    end
  end

  logic [127:0] ab2_5;
  logic [95:0]  detm5;
  logic [127:0] tripm5;
  side5_t       s5;

  always_ff @(posedge clk) begin
    if (en) begin
      ab2_5       <= ab2_c;
      detm5       <= det_c[97] ? 96'(-det_c) : 96'(det_c);
      tripm5      <= trip_c[129] ? 128'(-trip_c) : 128'(trip_c);
      s5.ab2      <= ab2_c;
      s5.aaw2     <= aaw2;
      s5.dab2     <= dab2;
      s5.aa       <= s2o.aa;
      s5.w2       <= s2o.w2;
      s5.f.neg_s  <= det_c[97] != s2o.wn;
      s5.f.tripn  <= trip_c[129];
      s5.f.dacn   <= s2o.dacn;
      s5.f.dabn   <= s2o.dabn;
      s5.f.wz     <= s2o.wz;
      s5.f.deg    <= (s2o.aa == 64'd0) || (ab2_c == 128'd0) || (det_c == 98'sd0);
    end
  end

  // Third multiply level
  logic [223:0] det2_f;
  logic [255:0] ab2w2;
  logic [255:0] trip2;
  logic [255:0] dac2ab2;
  logic [127:0] s5_dac2;
  logic [127:0] dac2_5;

  always_ff @(posedge clk) begin
    if (en) begin
      dac2_5 <= dac2;
    end
  end

  assign s5_dac2 = dac2_5;

  msd_mul #(.WA(96), .WB(128)) u_det2 (
    .clk(clk), .en(en), .a(detm5), .b(128'(detm5)), .p(det2_f));
  msd_mul #(.WA(128), .WB(128)) u_ab2w2 (
    .clk(clk), .en(en), .a(ab2_5), .b(128'(s5.w2)), .p(ab2w2));
  msd_mul #(.WA(128), .WB(128)) u_trip2 (
    .clk(clk), .en(en), .a(tripm5), .b(tripm5), .p(trip2));
  msd_mul #(.WA(128), .WB(128)) u_dac2ab2 (
    .clk(clk), .en(en), .a(s5.ab2), .b(s5_dac2), .p(dac2ab2));

  side5_t sd5 [L3_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd5[0] <= s5;
      for (int i = 1; i < L3_LAT; i++) begin
        sd5[i] <= sd5[i-1];
      end
    end
  end

  // Fourth multiply level: |a|^2 det^2
  side5_t       s9;
  logic [255:0] aaw;

  assign s9 = sd5[L3_LAT-1];

  msd_mul #(.WA(192), .WB(64)) u_aaw (
    .clk(clk), .en(en), .a(det2_f[191:0]), .b(s9.aa), .p(aaw));

  side9_t sd9 [L4_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      sd9[0] <= '{det2: det2_f[191:0], ab2w2: ab2w2, trip2: trip2,
                  dac2ab2: dac2ab2, ab2: s9.ab2, aaw2: s9.aaw2, dab2: s9.dab2,
                  aa: s9.aa, w2: s9.w2, f: s9.f};
      for (int i = 1; i < L4_LAT; i++) begin
        sd9[i] <= sd9[i-1];
      end
    end
  end

  // Square roots of the six ratios
  side9_t      s11;
  logic [31:0] q_sx;
  logic [31:0] q_sy;
  logic [31:0] q_sz;
  logic [31:0] q_yz;
  logic [31:0] q_xz;
  logic [31:0] q_xy;

  assign s11 = sd9[L4_LAT-1];

  msd_root #(.YW(256)) u_sx (.clk(clk), .en(en),
    .x(ROOT_W'(s11.aa) << (2*FRAC_BITS)), .y(256'(s11.w2)), .q(q_sx));
  msd_root #(.YW(256)) u_sy (.clk(clk), .en(en),
    .x(ROOT_W'(s11.ab2) << (2*FRAC_BITS)), .y(256'(s11.aaw2)), .q(q_sy));
  msd_root #(.YW(256)) u_sz (.clk(clk), .en(en),
    .x(ROOT_W'(s11.det2) << (2*FRAC_BITS)), .y(s11.ab2w2), .q(q_sz));
  msd_root #(.YW(256)) u_yz (.clk(clk), .en(en),
    .x(ROOT_W'(s11.trip2) << (2*FRAC_BITS)), .y(aaw), .q(q_yz));
  msd_root #(.YW(256)) u_xz (.clk(clk), .en(en),
    .x(ROOT_W'(s11.dac2ab2) << (2*FRAC_BITS)), .y(aaw), .q(q_xz));
  msd_root #(.YW(256)) u_xy (.clk(clk), .en(en),
    .x(ROOT_W'(s11.dab2) << (2*FRAC_BITS)), .y(256'(s11.ab2)), .q(q_xy));

  flags_t sdf [Q_W];
  always_ff @(posedge clk) begin
    if (en) begin
      sdf[0] <= s11.f;
      for (int i = 1; i < Q_W; i++) begin
        sdf[i] <= sdf[i-1];
      end
    end
  end

  // Sign, saturate and status
  flags_t   fl;
  msd_out_t res;

  assign fl = sdf[Q_W-1];

  always_comb begin
    res = '0;
    if (fl.wz) begin
      res.status = ST_CORNER_ZERO;
    end else if (fl.deg) begin
      res.status = ST_ZERO_COL;
    end else begin
      res.status   = ST_OK;
      res.scale_x  = fmt(q_sx, fl.neg_s);
      res.scale_y  = fmt(q_sy, fl.neg_s);
      res.scale_z  = fmt(q_sz, fl.neg_s);
      res.shear_yz = fmt(q_yz, fl.tripn);
      res.shear_xz = fmt(q_xz, fl.dacn);
      res.shear_xy = fmt(q_xy, fl.dabn);
    end
  end

  // Output register with skid: hold on stall, park the next word in skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || v[VLEN-1];
      skid_valid <= 1'b0;
    end else if (v[VLEN-1] && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid : res;
    end else if (!skid_valid) begin
      skid <= res;
    end
  end

endmodule

@@ rtl/msd_chk.sv @@
// ----------------------------------------------------------------------------
// msd_chk
// Port-level checks of the decomposer, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_scale_shear_decompose_top_defines.svh"

module msd_chk import msd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input msd_out_t out_data
);

  logic fields_zero;
  assign fields_zero = (out_data.scale_x == 32'sd0) && (out_data.scale_y == 32'sd0) &&
                       (out_data.scale_z == 32'sd0) && (out_data.shear_yz == 32'sd0) &&
                       (out_data.shear_xz == 32'sd0) && (out_data.shear_xy == 32'sd0);

  // A failed decomposition carries no factors
  `MSD_ASSERT(a_fail_zero, clk, rst, (out_valid && out_data.status != ST_OK) |-> fields_zero)

  // A stalled output word holds
  `MSD_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))

  // Input backpressure only follows a stalled output
  `MSD_ASSERT(a_stall_cause, clk, rst, $rose(in_stall) |-> $past(out_valid && out_stall))

  // Reset empties the output
  `MSD_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (!out_valid && !in_stall))

endmodule

bind matrix_scale_shear_decompose_top msd_chk u_msd_chk (.*);
